### src/pic_bilinear_deposit_gather_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PIC_BILINEAR_DEPOSIT_GATHER_UNIT_ASSERT_SVH
`define PIC_BILINEAR_DEPOSIT_GATHER_UNIT_ASSERT_SVH

// pre at one edge implies post at the next edge
`define PDG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// pre implies post at the same edge
`define PDG_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

### src/pdg_pkg.sv
// ----------------------------------------------------------------------------
// pdg_pkg
// Types and constants shared by the bilinear deposit/gather unit.
// ----------------------------------------------------------------------------
package pdg_pkg;

    localparam int GRID_W     = 32;
    localparam int GRID_H     = 32;
    localparam int NODE_COUNT = GRID_W * GRID_H;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int CX_W       = $clog2(GRID_W);
    localparam int CY_W       = $clog2(GRID_H);
    localparam int W_W        = 17;
    localparam int PROD_W     = W_W + 32;
    localparam int ACC_W      = PROD_W + 2;
    localparam int QDEPTH     = 4;
    localparam int Q_AW       = $clog2(QDEPTH);
    localparam int Q_CW       = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_DEPOSIT = 2'd1,
        ACT_GATHER  = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        action_t                   action;
        logic                      alive;
        logic [3:0][ADDR_W-1:0]    idx;
        logic [3:0][W_W-1:0]       w;
        logic [ADDR_W-1:0]         rd_idx;
        logic                      rd_ok;
    } pdg_cmd_t;

    typedef struct packed {
        logic     push;
        pdg_cmd_t data;
    } pdg_push_t;

endpackage

### src/pdg_front.sv
// ----------------------------------------------------------------------------
// pdg_front
// Accepts items, splits positions into cell and fraction, builds the
// corner indices and weights, and pushes a command into the queue.
// ----------------------------------------------------------------------------
module pdg_front
    import pdg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        action,
    input  logic [16:0]       pos_x,
    input  logic [16:0]       pos_y,
    input  logic              alive,
    input  logic [4:0]        node_col,
    input  logic [4:0]        node_row,
    input  logic              init_busy,
    input  logic              q_full,
    output pdg_push_t         q_in
);

    logic              vld_reg, vld_next;
    action_t           act_reg;
    logic              alive_reg;
    logic [CX_W-1:0]   cx_reg, cx_next;
    logic [CY_W-1:0]   cy_reg, cy_next;
    logic [15:0]       fx_reg, fx_next;
    logic [15:0]       fy_reg, fy_next;
    logic [4:0]        col_reg, row_reg;

    logic              accept;
    logic [15:0]       px, py;
    logic [16+CX_W-1:0] tx;
    logic [16+CY_W-1:0] ty;
    logic [W_W-1:0]    ax [2];
    logic [W_W-1:0]    ay [2];
    pdg_cmd_t          cmd;

    assign item_stall = init_busy || (vld_reg && q_full);
    assign accept     = item_valid && !item_stall;

    assign px = (pos_x >= 17'd65536) ? 16'hFFFF : pos_x[15:0];
    assign py = (pos_y >= 17'd65536) ? 16'hFFFF : pos_y[15:0];
    assign tx = (16+CX_W)'(px) * (16+CX_W)'(GRID_W - 1);
    assign ty = (16+CY_W)'(py) * (16+CY_W)'(GRID_H - 1);
    assign cx_next = tx[16+CX_W-1:16];
    assign cy_next = ty[16+CY_W-1:16];
    assign fx_next = tx[15:0];
    assign fy_next = ty[15:0];

    assign vld_next = accept || (vld_reg && q_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action_t'(action);
            alive_reg <= alive;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            fx_reg    <= fx_next;
            fy_reg    <= fy_next;
            col_reg   <= node_col;
            row_reg   <= node_row;
        end
    end

    assign ax[0] = W_W'(17'd65536 - {1'b0, fx_reg});
    assign ax[1] = {1'b0, fx_reg};
    assign ay[0] = W_W'(17'd65536 - {1'b0, fy_reg});
    assign ay[1] = {1'b0, fy_reg};

    always_comb
    begin
        logic [33:0] prod;
        cmd.action = act_reg;
        cmd.alive  = alive_reg;
        for (int k = 0; k < 4; k++)
        begin
            prod = 34'(ax[k & 1]) * 34'(ay[k >> 1]);
            cmd.w[k]   = W_W'((prod + 34'd32768) >> 16);
            cmd.idx[k] = ADDR_W'((32'(cy_reg) + 32'(k >> 1)) * 32'(GRID_W)
                                 + 32'(cx_reg) + 32'(k & 1));
        end
        cmd.rd_idx = ADDR_W'(32'(row_reg) * 32'(GRID_W) + 32'(col_reg));
        cmd.rd_ok  = (32'(col_reg) < 32'(GRID_W)) && (32'(row_reg) < 32'(GRID_H));
    end

    assign q_in.push = vld_reg && !q_full;
    assign q_in.data = cmd;

endmodule

### src/pdg_queue.sv
// ----------------------------------------------------------------------------
// pdg_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pdg_queue
    import pdg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pdg_push_t  q_in,
    output logic       q_full,
    input  logic       pop,
    output logic       q_empty,
    output pdg_cmd_t   head
);

    pdg_cmd_t          slot_reg [QDEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   cnt_reg, cnt_next;
    logic              do_pop;

    assign q_full  = (cnt_reg == Q_CW'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && !q_empty;

    always_comb
    begin
        wr_ptr_next = q_in.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CW'(q_in.push) - Q_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_in.push)
        begin
            slot_reg[wr_ptr_reg] <= q_in.data;
        end
    end

endmodule

### src/pdg_back.sv
// ----------------------------------------------------------------------------
// pdg_back
// Owns the mesh memory; runs clear sweeps, read-modify-write deposits,
// gathers and node reads; holds the result register.
// ----------------------------------------------------------------------------
module pdg_back
    import pdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  pdg_cmd_t    head,
    output logic        pop,
    output logic        init_busy,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] value,
    output logic        sat_seen
);

    logic [31:0]        mesh_mem [NODE_COUNT];
    logic [31:0]        rdata_reg;

    state_t             state_reg, state_next;
    pdg_cmd_t           cmd_reg, cmd_next;
    logic [1:0]         k_reg, k_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               init_reg, init_next;
    logic               sat_reg, sat_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               prod_vld_reg, prod_vld_next;
    logic               rv_reg, rv_next;
    logic [31:0]        value_reg, value_next;
    logic               sato_reg, sato_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [31:0]        mem_wdata;
    logic               go;
    logic               clr_last;
    logic [32:0]        dep_sum;
    logic [ACC_W-1:0]   rnd;
    logic [ACC_W-17:0]  shifted;

    assign go        = (state_reg == ST_IDLE) && !q_empty && (!rv_reg || !result_stall);
    assign clr_last  = (clr_reg == ADDR_W'(NODE_COUNT - 1));
    assign dep_sum   = {1'b0, rdata_reg} + 33'(cmd_reg.w[k_reg]);
    assign rnd       = acc_reg + ACC_W'(32768);
    assign shifted   = rnd[ACC_W-1:16];
    assign init_busy = init_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (go)
                begin
                    unique case (head.action) inside
                        ACT_CLEAR:               state_next = ST_CLEAR;
                        ACT_DEPOSIT, ACT_GATHER: state_next = head.alive ? ST_UPD : ST_IDLE;
                        ACT_READ:                state_next = head.rd_ok ? ST_UPD : ST_IDLE;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UPD:
            begin
                if (cmd_reg.action == ACT_READ)
                begin
                    state_next = ST_IDLE;
                end
                else if (k_reg == 2'd3)
                begin
                    state_next = (cmd_reg.action == ACT_GATHER) ? ST_ACC : ST_IDLE;
                end
            end
            ST_ACC:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        cmd_next      = cmd_reg;
        k_next        = k_reg;
        clr_next      = clr_reg;
        init_next     = init_reg;
        sat_next      = sat_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        prod_vld_next = 1'b0;
        rv_next       = rv_reg && result_stall;
        value_next    = value_reg;
        sato_next     = sato_reg;
        mem_we        = 1'b0;
        mem_waddr     = cmd_reg.idx[k_reg];
        mem_wdata     = '0;
        mem_raddr     = cmd_reg.idx[k_reg + 2'd1];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_last)
                begin
                    init_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                mem_raddr = (head.action == ACT_READ) ? head.rd_idx : head.idx[0];
                if (go)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    k_next   = '0;
                    acc_next = '0;
                    case (head.action)
                        ACT_CLEAR:
                        begin
                            clr_next = '0;
                            sat_next = 1'b0;
                        end
                        ACT_GATHER:
                        begin
                            if (!head.alive)
                            begin
                                rv_next    = 1'b1;
                                value_next = '0;
                                sato_next  = sat_reg;
                            end
                        end
                        ACT_READ:
                        begin
                            if (!head.rd_ok)
                            begin
                                rv_next    = 1'b1;
                                value_next = '0;
                                sato_next  = sat_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_UPD:
            begin
                case (cmd_reg.action)
                    ACT_DEPOSIT:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = dep_sum[32] ? 32'hFFFF_FFFF : dep_sum[31:0];
                        if (dep_sum[32])
                        begin
                            sat_next = 1'b1;
                        end
                        k_next = k_reg + 2'd1;
                    end
                    ACT_GATHER:
                    begin
                        prod_next     = PROD_W'(cmd_reg.w[k_reg]) * PROD_W'(rdata_reg);
                        prod_vld_next = 1'b1;
                        if (prod_vld_reg)
                        begin
                            acc_next = acc_reg + ACC_W'(prod_reg);
                        end
                        k_next = k_reg + 2'd1;
                    end
                    default:
                    begin
                        rv_next    = 1'b1;
                        value_next = rdata_reg;
                        sato_next  = sat_reg;
                    end
                endcase
            end
            ST_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
            ST_FIN:
            begin
                rv_next    = 1'b1;
                value_next = (|shifted[ACC_W-17:32]) ? 32'hFFFF_FFFF : shifted[31:0];
                sato_next  = sat_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            k_reg        <= '0;
            clr_reg      <= '0;
            init_reg     <= 1'b1;
            sat_reg      <= 1'b0;
            prod_vld_reg <= 1'b0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            clr_reg      <= clr_next;
            init_reg     <= init_next;
            sat_reg      <= sat_next;
            prod_vld_reg <= prod_vld_next;
            rv_reg       <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        value_reg <= value_next;
        sato_reg  <= sato_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mesh_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mesh_mem[mem_raddr];
    end

    assign result_valid = rv_reg;
    assign value        = value_reg;
    assign sat_seen     = sato_reg;

endmodule

### src/pic_bilinear_deposit_gather_unit.sv
// ----------------------------------------------------------------------------
// pic_bilinear_deposit_gather_unit
// Bilinear cloud-in-cell deposit and gather on a Q16.16 mesh.
//
//   channel | signals                                       | transfer
//   item    | item_valid item_stall action pos_x pos_y      | valid & !stall
//           | alive node_col node_row                       |
//   result  | result_valid result_stall value sat_seen      | valid & !stall
//
// Deposit: four read-modify-writes on the single mesh write port.
// Gather: four reads through one multiplier and accumulator.
// Clear: one node per cycle over all NODE_COUNT nodes.
// After reset a clearing pass runs with item_stall high.
// A stalled result holds the back; the queue keeps the front taking items until it fills.
// ----------------------------------------------------------------------------
module pic_bilinear_deposit_gather_unit
    import pdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  action,
    input  logic [16:0] pos_x,
    input  logic [16:0] pos_y,
    input  logic        alive,
    input  logic [4:0]  node_col,
    input  logic [4:0]  node_row,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] value,
    output logic        sat_seen
);

    pdg_push_t q_in;
    pdg_cmd_t  head;
    logic      q_full;
    logic      q_empty;
    logic      pop;
    logic      init_busy;

    pdg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .action     (action),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .alive      (alive),
        .node_col   (node_col),
        .node_row   (node_row),
        .init_busy  (init_busy),
        .q_full     (q_full),
        .q_in       (q_in)
    );

    pdg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_in    (q_in),
        .q_full  (q_full),
        .pop     (pop),
        .q_empty (q_empty),
        .head    (head)
    );

    pdg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head         (head),
        .pop          (pop),
        .init_busy    (init_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .sat_seen     (sat_seen)
    );

endmodule

### src/pdg_checker.sv
// ----------------------------------------------------------------------------
// pdg_checker
// Port-level checks on the deposit/gather unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "pic_bilinear_deposit_gather_unit_assert.svh"

module pdg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] value,
    input logic        sat_seen
);

    `PDG_ASSERT_NEXT(a_res_hold, clk, rst_n, result_valid && result_stall, result_valid, "result dropped while stalled")
    `PDG_ASSERT_NEXT(a_res_stable, clk, rst_n, result_valid && result_stall, $stable(value) && $stable(sat_seen), "stalled result changed")
    `PDG_ASSERT_NOW(a_init_stall, clk, rst_n, $rose(rst_n), item_stall, "item taken during clearing pass")
    `PDG_ASSERT_NEXT(a_init_quiet, clk, rst_n, $rose(rst_n), !result_valid, "result during clearing pass")

endmodule

bind pic_bilinear_deposit_gather_unit pdg_checker u_pdg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .sat_seen     (sat_seen)
);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear deposit/gather unit. A directed table
// covers clear, position extremes, inactive particles and node reads, then
// repeated deposits on one node and random traffic (mostly deposits on a
// small hot region, with gathers and reads) are scored against a behavioral
// mesh model under varying sender/receiver idle patterns and a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb;
    import pdg_pkg::*;

    localparam int WDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  action;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic        alive;
    logic [4:0]  node_col;
    logic [4:0]  node_row;
    logic        result_valid;
    logic        result_stall;
    logic [31:0] value;
    logic        sat_seen;

    pic_bilinear_deposit_gather_unit DUT (.*);

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } result_t;

    typedef struct {
        action_t     act;
        logic [16:0] px;
        logic [16:0] py;
        logic        live;
        logic [4:0]  col;
        logic [4:0]  row;
        logic        fixed;
        logic [31:0] fixed_value;
    } stim_row_t;

    logic [31:0] mesh_model [NODE_COUNT];
    logic        sat_model;
    result_t     expected_q[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          recv_hold;
    int          quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void corner_weights(input logic [16:0] px, input logic [16:0] py,
                                           output logic [ADDR_W-1:0] idx[4],
                                           output logic [31:0] w[4]);
        logic [31:0] cx, cy, fx, fy;
        logic [63:0] tx, ty, prod;
        logic [31:0] ax[2], ay[2];
        tx = (px >= 17'd65536 ? 64'd65535 : 64'(px)) * (GRID_W - 1);
        ty = (py >= 17'd65536 ? 64'd65535 : 64'(py)) * (GRID_H - 1);
        cx = 32'(tx >> 16);
        cy = 32'(ty >> 16);
        fx = 32'(tx & 64'hFFFF);
        fy = 32'(ty & 64'hFFFF);
        ax[0] = 32'd65536 - fx;
        ax[1] = fx;
        ay[0] = 32'd65536 - fy;
        ay[1] = fy;
        for (int k = 0; k < 4; k++)
        begin
            prod = 64'(ax[k & 1]) * 64'(ay[k >> 1]);
            w[k] = 32'((prod + 64'd32768) >> 16);
            idx[k] = ADDR_W'(((cy + (k >> 1)) * GRID_W + cx + (k & 1)) % NODE_COUNT);
        end
    endfunction

    // Updates the mesh model; returns 1 when the item yields a result.
    function automatic bit mesh_predict(input action_t act, input logic [16:0] px,
                                        input logic [16:0] py, input logic live,
                                        input logic [4:0] col, input logic [4:0] row,
                                        output result_t res);
        logic [ADDR_W-1:0] idx[4];
        logic [31:0] w[4];
        logic [63:0] sum;
        res = '0;
        case (act)
            ACT_CLEAR:
            begin
                foreach (mesh_model[i]) mesh_model[i] = '0;
                sat_model = 1'b0;
                return 0;
            end
            ACT_DEPOSIT:
            begin
                if (live)
                begin
                    corner_weights(px, py, idx, w);
                    for (int k = 0; k < 4; k++)
                    begin
                        sum = 64'(mesh_model[idx[k]]) + 64'(w[k]);
                        if (sum > 64'hFFFF_FFFF)
                        begin
                            sum = 64'hFFFF_FFFF;
                            sat_model = 1'b1;
                        end
                        mesh_model[idx[k]] = sum[31:0];
                    end
                end
                return 0;
            end
            ACT_GATHER:
            begin
                if (live)
                begin
                    corner_weights(px, py, idx, w);
                    sum = '0;
                    for (int k = 0; k < 4; k++)
                        sum += 64'(w[k]) * 64'(mesh_model[idx[k]]);
                    sum = (sum + 64'd32768) >> 16;
                    res.value = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
            default:
            begin
                if (col < GRID_W && row < GRID_H)
                    res.value = mesh_model[ADDR_W'(row * GRID_W + col)];
            end
        endcase
        res.sat = sat_model;
        return 1;
    endfunction

    task automatic send_item(input action_t act, input logic [16:0] px,
                             input logic [16:0] py, input logic live,
                             input logic [4:0] col, input logic [4:0] row);
        result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        action     <= act;
        pos_x      <= px;
        pos_y      <= py;
        alive      <= live;
        node_col   <= col;
        node_row   <= row;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (mesh_predict(act, px, py, live, col, row, res))
            expected_q.push_back(res);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [16:0] rand_pos();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'(65535 - $urandom_range(3));
            3: return 17'($urandom_range(131071));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
        action_t act;
        logic [16:0] px, py;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            act  = pick < 55 ? ACT_DEPOSIT : pick < 78 ? ACT_GATHER :
                   pick < 99 ? ACT_READ : ACT_CLEAR;
            if ($urandom_range(3) == 0)
            begin
                px = rand_pos();
                py = rand_pos();
            end
            else
            begin
                px = 17'($urandom_range(4095));
                py = 17'($urandom_range(4095));
            end
            send_item(act, px, py, $urandom_range(9) != 0,
                      $urandom_range(3) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(2)),
                      $urandom_range(3) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(2)));
        end
    endtask

    stim_row_t directed[] = '{
        '{ACT_READ,    17'd0,     17'd0,     1'b1, 5'd0,  5'd0,  1'b1, 32'd0},
        '{ACT_GATHER,  17'd65536, 17'd65536, 1'b1, 5'd0,  5'd0,  1'b1, 32'd0},
        '{ACT_DEPOSIT, 17'd0,     17'd0,     1'b1, 5'd0,  5'd0,  1'b0, 32'd0},
        '{ACT_READ,    17'd0,     17'd0,     1'b0, 5'd0,  5'd0,  1'b1, 32'h10000},
        '{ACT_DEPOSIT, 17'd65536, 17'd65536, 1'b1, 5'd0,  5'd0,  1'b0, 32'd0},
        '{ACT_DEPOSIT, 17'd65535, 17'd0,     1'b1, 5'd0,  5'd0,  1'b0, 32'd0},
        '{ACT_DEPOSIT, 17'd131071,17'd98304, 1'b0, 5'd0,  5'd0,  1'b0, 32'd0},
        '{ACT_DEPOSIT, 17'd32768, 17'd32768, 1'b1, 5'd0,  5'd0,  1'b0, 32'd0},
        '{ACT_READ,    17'd0,     17'd0,     1'b1, 5'd31, 5'd31, 1'b0, 32'd0},
        '{ACT_READ,    17'd0,     17'd0,     1'b1, 5'd30, 5'd31, 1'b0, 32'd0},
        '{ACT_READ,    17'd0,     17'd0,     1'b1, 5'd31, 5'd0,  1'b0, 32'd0},
        '{ACT_GATHER,  17'd0,     17'd0,     1'b0, 5'd0,  5'd0,  1'b1, 32'd0},
        '{ACT_GATHER,  17'd0,     17'd0,     1'b1, 5'd0,  5'd0,  1'b1, 32'h10000},
        '{ACT_GATHER,  17'd65536, 17'd65536, 1'b1, 5'd0,  5'd0,  1'b0, 32'd0},
        '{ACT_GATHER,  17'd32768, 17'd32768, 1'b1, 5'd0,  5'd0,  1'b0, 32'd0},
        '{ACT_GATHER,  17'd21000, 17'd40000, 1'b1, 5'd0,  5'd0,  1'b0, 32'd0},
        '{ACT_CLEAR,   17'd0,     17'd0,     1'b0, 5'd0,  5'd0,  1'b0, 32'd0},
        '{ACT_READ,    17'd0,     17'd0,     1'b1, 5'd0,  5'd0,  1'b1, 32'd0},
        '{ACT_READ,    17'd0,     17'd0,     1'b1, 5'd31, 5'd31, 1'b1, 32'd0}
    };

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b1;
        else
            result_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", value, 32'd0);
            end
            else
            begin
                result_t want;
                want = expected_q.pop_front();
                if (value !== want.value)
                    report_mismatch("value", value, want.value);
                if (sat_seen !== want.sat)
                    report_mismatch("sat_seen", 32'(sat_seen), 32'(want.sat));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        item_valid = 1'b0;
        action = ACT_CLEAR;
        pos_x = '0;
        pos_y = '0;
        alive = 1'b0;
        node_col = '0;
        node_row = '0;
        foreach (mesh_model[i]) mesh_model[i] = '0;
        sat_model = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            send_item(directed[i].act, directed[i].px, directed[i].py, directed[i].live,
                      directed[i].col, directed[i].row);
            if (directed[i].fixed && directed[i].act != ACT_CLEAR
                && directed[i].act != ACT_DEPOSIT)
                expected_q[$].value = directed[i].fixed_value;
        end
        drain_results();

        // repeated deposits on node 0 with reads in between
        for (int n = 0; n < 8; n++)
        begin
            for (int m = 0; m < 8; m++)
                send_item(ACT_DEPOSIT, 17'd0, 17'd0, 1'b1, 5'd0, 5'd0);
            send_item(ACT_READ, 17'd0, 17'd0, 1'b1, 5'd0, 5'd0);
        end
        drain_results();

        random_phase(300, 0, 0);
        drain_results();

        // long receiver hold-off while the sender keeps pushing
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
            random_phase(60, 0, 0);
        join
        drain_results();

        random_phase(300, 67, 0);
        drain_results();
        random_phase(300, 0, 67);
        drain_results();
        random_phase(300, 36, 36);
        send_item(ACT_CLEAR, 17'd0, 17'd0, 1'b0, 5'd0, 5'd0);
        send_item(ACT_READ, 17'd0, 17'd0, 1'b1, 5'd1, 5'd0);
        drain_results();
        repeat (50) @(posedge clk);

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/pdg_pkg.sv
src/pdg_front.sv
src/pdg_queue.sv
src/pdg_back.sv
src/pic_bilinear_deposit_gather_unit.sv
src/pdg_checker.sv
tb/tb.sv
